@@ rtl/core/awv_pkg.sv @@
// shared types and constants for the activity window volume block
`timescale 1ns / 1ps

package awv_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 64;
  localparam int GAIN_W     = 5;
  localparam int SCALED_W   = 16;
  localparam int RATE_W     = 16;
  localparam int COUNT_CFG_W = 6;
  localparam int VOLUME_W   = 16;
  localparam int ACTIVE_W   = 5;
  localparam int CMP_W      = 11;
  localparam int STEP_W     = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int WINDOW_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_VOLUME    = 3'd4;

  localparam logic [GAIN_W-1:0]      GAIN_RST      = 5'd1;
  localparam logic [RATE_W-1:0]      THRESHOLD_RST = 16'd100;
  localparam logic [COUNT_CFG_W-1:0] COUNT_LOW_RST = 6'd4;
  localparam logic [COUNT_CFG_W-1:0] COUNT_HIGH_RST = 6'd20;
  localparam logic [VOLUME_W-1:0]    CLIP_VOLUME_RST = 16'd16;

  // one classified word between front and back
  typedef struct packed {
    logic [SCALED_W-1:0] delta;
    logic [RATE_W-1:0]   divisor;
    logic                big;      // elapsed time of 2^16 or more, quotient is zero
  } awv_item_t;

  typedef struct packed {
    logic [RATE_W-1:0]      rate_threshold;
    logic [COUNT_CFG_W-1:0] count_low;
    logic [COUNT_CFG_W-1:0] count_high;
    logic [VOLUME_W-1:0]    clip_volume;
  } awv_cfg_t;

endpackage

@@ rtl/core/activity_window_volume.sv @@
// top level: config registers, front end, queue and back end of the volume block
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid/in_ready    in_sample[11:0], in_time_us[63:0]
//   out_*        out   out_valid/out_ready  out_volume[15:0], out_change_rate[15:0],
//                                           out_active_count[4:0]
//   cfg_*        in    cfg_valid/cfg_ready  cfg_index[2:0], cfg_data[15:0]
//
// the back end takes one word at a time: a load, 16 divider steps, then a finish step
// the front end accepts a sample whenever the queue has room
// reset is synchronous, active low; the flag ring needs no clearing pass
// a stalled output holds the back end in its finish step; the queue keeps filling
`timescale 1ns / 1ps

module activity_window_volume #(
  parameter int WINDOW_DEPTH = awv_pkg::WINDOW_DEPTH_DEF,
  parameter int QUEUE_DEPTH  = awv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [awv_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic [awv_pkg::TIME_W-1:0]       in_time_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [awv_pkg::VOLUME_W-1:0]     out_volume,
  output logic [awv_pkg::RATE_W-1:0]       out_change_rate,
  output logic [awv_pkg::ACTIVE_W-1:0]     out_active_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [awv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [awv_pkg::GAIN_W-1:0] gain_r;
  awv_pkg::awv_cfg_t          cfg_r;
  logic                       cfg_we;

  logic                       q_full;
  logic                       q_push;
  awv_pkg::awv_item_t         q_push_item;
  logic                       q_pop;
  logic                       q_valid;
  awv_pkg::awv_item_t         q_item;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r               <= awv_pkg::GAIN_RST;
      cfg_r.rate_threshold <= awv_pkg::THRESHOLD_RST;
      cfg_r.count_low      <= awv_pkg::COUNT_LOW_RST;
      cfg_r.count_high     <= awv_pkg::COUNT_HIGH_RST;
      cfg_r.clip_volume    <= awv_pkg::CLIP_VOLUME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        awv_pkg::REG_SAMPLE_GAIN:    gain_r <= cfg_data[awv_pkg::GAIN_W-1:0];
        awv_pkg::REG_RATE_THRESHOLD: cfg_r.rate_threshold <= cfg_data;
        awv_pkg::REG_COUNT_LOW:      cfg_r.count_low <= cfg_data[awv_pkg::COUNT_CFG_W-1:0];
        awv_pkg::REG_COUNT_HIGH:     cfg_r.count_high <= cfg_data[awv_pkg::COUNT_CFG_W-1:0];
        awv_pkg::REG_CLIP_VOLUME:    cfg_r.clip_volume <= cfg_data;
        default: ;
      endcase
    end
  end

  awv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_time_us  (in_time_us),
    .sample_gain (gain_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_push_item)
  );

  awv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  awv_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .cfg              (cfg_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_volume       (out_volume),
    .out_change_rate  (out_change_rate),
    .out_active_count (out_active_count)
  );

endmodule

@@ rtl/core/awv_front.sv @@
// front end: accepts samples, scales them and forms the change and elapsed time
`timescale 1ns / 1ps

module awv_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [awv_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [awv_pkg::TIME_W-1:0]      in_time_us,
  input  logic [awv_pkg::GAIN_W-1:0]      sample_gain,
  input  logic                            q_full,
  output logic                            q_push,
  output awv_pkg::awv_item_t              q_item
);

  logic [awv_pkg::SCALED_W-1:0] prev_sample_r;
  logic [awv_pkg::TIME_W-1:0]   prev_time_r;
  logic [awv_pkg::SCALED_W:0]   product;
  logic [awv_pkg::SCALED_W-1:0] scaled;
  logic [awv_pkg::TIME_W-1:0]   elapsed;
  logic                         big;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    product = (awv_pkg::SCALED_W + 1)'(in_sample) * (awv_pkg::SCALED_W + 1)'(sample_gain);
    scaled  = product[awv_pkg::SCALED_W-1:0];
    elapsed = in_time_us - prev_time_r;
    big     = |elapsed[awv_pkg::TIME_W-1:awv_pkg::RATE_W];
    q_item.delta = (scaled >= prev_sample_r) ? (scaled - prev_sample_r)
                                             : (prev_sample_r - scaled);
    q_item.big   = big;
    // zero elapsed time divides by one
    if (elapsed[awv_pkg::RATE_W-1:0] == '0) begin
      q_item.divisor = awv_pkg::RATE_W'(1);
    end else begin
      q_item.divisor = elapsed[awv_pkg::RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      prev_time_r   <= '0;
    end else if (q_push) begin
      prev_sample_r <= scaled;
      prev_time_r   <= in_time_us;
    end
  end

endmodule

@@ rtl/core/awv_queue.sv @@
// short fifo of classified words between front and back
`timescale 1ns / 1ps

module awv_queue #(
  parameter int DEPTH = awv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  awv_pkg::awv_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output awv_pkg::awv_item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  awv_pkg::awv_item_t entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;

  assign full      = (fill_r == CW'(DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

endmodule

@@ rtl/core/awv_back.sv @@
// back end: radix-2 divider, activity ring, window count and volume mapping
`timescale 1ns / 1ps

module awv_back #(
  parameter int WINDOW_DEPTH = awv_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  awv_pkg::awv_item_t              q_item,
  output logic                            q_pop,
  input  awv_pkg::awv_cfg_t               cfg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [awv_pkg::VOLUME_W-1:0]    out_volume,
  output logic [awv_pkg::RATE_W-1:0]      out_change_rate,
  output logic [awv_pkg::ACTIVE_W-1:0]    out_active_count
);

  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(WINDOW_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  logic [awv_pkg::RATE_W-1:0] rem_r;
  logic [awv_pkg::RATE_W-1:0] quo_r;
  logic [awv_pkg::RATE_W-1:0] div_r;
  logic                       big_r;
  logic [awv_pkg::STEP_W-1:0] step_r;
  logic [awv_pkg::RATE_W:0]   rem_shift;
  logic                       sub_ok;

  logic                       flag_mem [WINDOW_DEPTH];
  logic                       old_flag_r;
  logic                       old_valid_r;
  logic [PW-1:0]              pos_r;
  logic [PW-1:0]              pos_next;
  logic                       wrapped_r;
  logic [PW-1:0]              count_r;
  logic [PW-1:0]              count_nxt;

  logic [awv_pkg::RATE_W-1:0] rate;
  logic                       active;
  logic                       finish;
  logic [awv_pkg::CMP_W-1:0]  cnt_ext;
  logic [awv_pkg::CMP_W-1:0]  low_ext;
  logic [awv_pkg::CMP_W-1:0]  high_ext;
  logic [awv_pkg::VOLUME_W-1:0] volume;

  logic                       out_valid_r;
  logic [awv_pkg::VOLUME_W-1:0] out_volume_r;
  logic [awv_pkg::RATE_W-1:0]   out_rate_r;
  logic [awv_pkg::ACTIVE_W-1:0] out_count_r;

  assign out_valid        = out_valid_r;
  assign out_volume       = out_volume_r;
  assign out_change_rate  = out_rate_r;
  assign out_active_count = out_count_r;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign pos_next = (pos_r == LAST_POS) ? '0 : pos_r + PW'(1);
  assign finish   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // one restoring step per cycle
  always_comb begin
    rem_shift = {rem_r, quo_r[awv_pkg::RATE_W-1]};
    sub_ok    = (rem_shift >= {1'b0, div_r});
  end

  always_comb begin
    rate      = big_r ? '0 : quo_r;
    active    = (rate > cfg.rate_threshold);
    count_nxt = count_r + PW'(active) - PW'(old_flag_r && old_valid_r);
    cnt_ext   = awv_pkg::CMP_W'(count_nxt);
    low_ext   = awv_pkg::CMP_W'(cfg.count_low);
    high_ext  = awv_pkg::CMP_W'(cfg.count_high);
    priority if (cnt_ext <= low_ext) begin
      volume = '0;
    end else if (cnt_ext <= high_ext) begin
      volume = awv_pkg::VOLUME_W'(cnt_ext - low_ext);
    end else begin
      volume = cfg.clip_volume;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (step_r == '1) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // flag ring: read the entry about to leave the window, write the new decision
  always_ff @(posedge clk) begin
    if (q_pop) begin
      old_flag_r <= flag_mem[pos_next];
    end
    if (finish) begin
      flag_mem[pos_r] <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_r <= '0;
      quo_r <= q_item.delta;
      div_r <= q_item.divisor;
      big_r <= q_item.big;
    end else if (state_r == ST_DIV) begin
      rem_r <= sub_ok ? awv_pkg::RATE_W'(rem_shift - {1'b0, div_r})
                      : rem_shift[awv_pkg::RATE_W-1:0];
      quo_r <= {quo_r[awv_pkg::RATE_W-2:0], sub_ok};
    end
    if (finish) begin
      out_volume_r <= volume;
      out_rate_r   <= rate;
      out_count_r  <= cnt_ext[awv_pkg::ACTIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pos_r       <= '0;
      wrapped_r   <= 1'b0;
      count_r     <= '0;
      old_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        step_r <= '0;
        // entries not yet written since reset count as clear
        old_valid_r <= wrapped_r || (pos_r == LAST_POS);
      end else if (state_r == ST_DIV) begin
        step_r <= step_r + awv_pkg::STEP_W'(1);
      end
      if (finish) begin
        pos_r   <= pos_next;
        count_r <= count_nxt;
        if (pos_r == LAST_POS) wrapped_r <= 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench for activity_window_volume: scoreboard against an in-bench rate and window predictor
`timescale 1ns / 1ps

module tb;

  localparam logic [awv_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  typedef struct {
    logic [awv_pkg::VOLUME_W-1:0] volume;
    logic [awv_pkg::RATE_W-1:0]   rate;
    logic [awv_pkg::ACTIVE_W-1:0] count;
  } vol_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [awv_pkg::SAMPLE_W-1:0]   in_sample;
  logic [awv_pkg::TIME_W-1:0]     in_time_us;
  logic                           out_valid;
  logic                           out_ready;
  logic [awv_pkg::VOLUME_W-1:0]   out_volume;
  logic [awv_pkg::RATE_W-1:0]     out_change_rate;
  logic [awv_pkg::ACTIVE_W-1:0]   out_active_count;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [awv_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [awv_pkg::CFG_DATA_W-1:0] cfg_data;

  activity_window_volume uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_time_us       (in_time_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_volume       (out_volume),
    .out_change_rate  (out_change_rate),
    .out_active_count (out_active_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // predictor copy of the registers
  logic [awv_pkg::GAIN_W-1:0]      gain_r;
  logic [awv_pkg::RATE_W-1:0]      thresh_r;
  logic [awv_pkg::COUNT_CFG_W-1:0] low_r;
  logic [awv_pkg::COUNT_CFG_W-1:0] high_r;
  logic [awv_pkg::VOLUME_W-1:0]    maxvol_r;

  // predictor copy of the state
  logic [awv_pkg::SCALED_W-1:0] last_scaled;
  logic [awv_pkg::TIME_W-1:0]   last_time;
  logic                         flag_ring [awv_pkg::WINDOW_DEPTH_DEF];
  int                           ring_ptr;
  int                           act_count;

  vol_result_t volume_due [$];
  int          fail_count;
  bit          no_gaps;
  bit          no_stalls;

  // last word sent, used to build the next one
  logic [awv_pkg::SAMPLE_W-1:0] stim_sample;
  logic [awv_pkg::TIME_W-1:0]   stim_time;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic predict_word(input logic [awv_pkg::SAMPLE_W-1:0] s,
                              input logic [awv_pkg::TIME_W-1:0] t);
    logic [awv_pkg::SCALED_W-1:0] scaled;
    logic [awv_pkg::SCALED_W-1:0] delta;
    logic [awv_pkg::TIME_W-1:0]   elapsed;
    logic [awv_pkg::RATE_W-1:0]   rate;
    logic                         hot;
    vol_result_t                  r;
    scaled = awv_pkg::SCALED_W'(32'(s) * 32'(gain_r));
    delta = (scaled >= last_scaled) ? scaled - last_scaled : last_scaled - scaled;
    elapsed = t - last_time;
    if (elapsed == '0) elapsed = awv_pkg::TIME_W'(1);
    rate = awv_pkg::RATE_W'(64'(delta) / elapsed);
    hot = rate > thresh_r;
    flag_ring[ring_ptr] = hot;
    ring_ptr = (ring_ptr + 1) % awv_pkg::WINDOW_DEPTH_DEF;
    if (hot) act_count++;
    // the slot now under the pointer is the oldest flag, it leaves the window
    if (flag_ring[ring_ptr]) act_count--;
    last_scaled = scaled;
    last_time = t;
    if (act_count <= int'(low_r)) r.volume = '0;
    else if (act_count <= int'(high_r)) r.volume = awv_pkg::VOLUME_W'(act_count - int'(low_r));
    else r.volume = maxvol_r;
    r.rate = rate;
    r.count = awv_pkg::ACTIVE_W'(act_count);
    volume_due.push_back(r);
  endtask

  task automatic send_word(input logic [awv_pkg::SAMPLE_W-1:0] s,
                           input logic [awv_pkg::TIME_W-1:0] t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    in_time_us = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(s, t);
    stim_sample = s;
    stim_time = t;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (volume_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [awv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [awv_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      awv_pkg::REG_SAMPLE_GAIN:    gain_r = data[awv_pkg::GAIN_W-1:0];
      awv_pkg::REG_RATE_THRESHOLD: thresh_r = data[awv_pkg::RATE_W-1:0];
      awv_pkg::REG_COUNT_LOW:      low_r = data[awv_pkg::COUNT_CFG_W-1:0];
      awv_pkg::REG_COUNT_HIGH:     high_r = data[awv_pkg::COUNT_CFG_W-1:0];
      awv_pkg::REG_CLIP_VOLUME:    maxvol_r = data[awv_pkg::VOLUME_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // writes every register, unused upper data bits random
  task automatic apply_settings(input logic [awv_pkg::GAIN_W-1:0] g,
                                input logic [awv_pkg::RATE_W-1:0] thr,
                                input logic [awv_pkg::COUNT_CFG_W-1:0] lo,
                                input logic [awv_pkg::COUNT_CFG_W-1:0] hi,
                                input logic [awv_pkg::VOLUME_W-1:0] mx);
    wait_idle();
    cfg_write(awv_pkg::REG_SAMPLE_GAIN, {11'($urandom), g});
    cfg_write(awv_pkg::REG_RATE_THRESHOLD, thr);
    cfg_write(awv_pkg::REG_COUNT_LOW, {10'($urandom), lo});
    cfg_write(awv_pkg::REG_COUNT_HIGH, {10'($urandom), hi});
    cfg_write(awv_pkg::REG_CLIP_VOLUME, mx);
    // index past the register list must change nothing
    cfg_write(REG_UNUSED_FIRST + awv_pkg::CFG_IDX_W'($urandom_range(2)), 16'($urandom));
  endtask

  // first word after reset, zero elapsed time, wrapping and backward timestamps
  task automatic test_time_edges();
    send_word(12'hFFF, 64'd0);
    send_word(12'h000, 64'd0);
    send_word(12'hFFF, 64'd1);
    send_word(12'h000, 64'd3);
    send_word(12'h001, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(12'hFFF, 64'd0);
    send_word(12'hFFE, 64'd10);
    send_word(12'h000, 64'd5);
    send_word(12'hFFF, 64'h8000_0000_0000_0000);
    send_word(12'hFFF, 64'h8000_0000_0000_0001);
    for (int i = 0; i < 6; i++) begin
      send_word((i % 2) ? 12'hFFF : 12'h000, stim_time + 64'd1);
    end
  endtask

  // gain extremes and truncation, divisor sizes around 2^16
  task automatic test_gain_edges();
    wait_idle();
    cfg_write(awv_pkg::REG_SAMPLE_GAIN, 16'd16);
    send_word(12'hFFF, stim_time + 64'd100);
    send_word(12'h000, stim_time + 64'd65520);
    send_word(12'hFFF, stim_time + 64'd65536);
    send_word(12'h000, stim_time + 64'd2);
    wait_idle();
    cfg_write(awv_pkg::REG_SAMPLE_GAIN, 16'd31);
    send_word(12'hFFF, stim_time + 64'd1);
    wait_idle();
    cfg_write(awv_pkg::REG_SAMPLE_GAIN, 16'd0);
    send_word(12'hFFF, stim_time + 64'd1);
    send_word(12'hFFF, stim_time);
    wait_idle();
    cfg_write(awv_pkg::REG_SAMPLE_GAIN, 16'd17);
    send_word(12'hFFF, stim_time + 64'd1);
  endtask

  // phases of settings, bursts of activity that sweep the window count
  task automatic test_random_phases();
    int                              busy;
    logic [awv_pkg::SAMPLE_W-1:0]    s;
    logic [awv_pkg::TIME_W-1:0]      t;
    logic [awv_pkg::GAIN_W-1:0]      g;
    logic [awv_pkg::RATE_W-1:0]      thr;
    logic [awv_pkg::COUNT_CFG_W-1:0] lo;
    logic [awv_pkg::COUNT_CFG_W-1:0] hi;
    logic [awv_pkg::VOLUME_W-1:0]    mx;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin g = 5'd16; thr = 16'd0;     lo = 6'd0;  hi = 6'd63; mx = 16'hFFFF; end
        1: begin g = 5'd31; thr = 16'hFFFF;  lo = 6'd63; hi = 6'd0;  mx = 16'h0000; end
        2: begin g = 5'd1;  thr = 16'd0;     lo = 6'd31; hi = 6'd0;  mx = 16'h5A5A; end
        3: begin g = 5'd0;  thr = 16'd100;   lo = 6'd4;  hi = 6'd20; mx = 16'd16;   end
        default: begin
          case ($urandom_range(4))
            0: g = 5'd0;
            1: g = 5'd1;
            2: g = 5'd16;
            3: g = 5'd31;
            default: g = 5'($urandom);
          endcase
          case ($urandom_range(3))
            0: thr = 16'd0;
            1: thr = 16'hFFFF;
            2: thr = 16'($urandom_range(3000));
            default: thr = 16'($urandom);
          endcase
          lo = 6'($urandom_range(40));
          hi = 6'($urandom_range(63));
          mx = 16'($urandom);
        end
      endcase
      apply_settings(g, thr, lo, hi, mx);
      for (int seg = 0; seg < 6; seg++) begin
        busy = $urandom_range(4);
        no_gaps = ($urandom_range(3) == 0);
        no_stalls = ($urandom_range(3) == 0);
        for (int i = 0; i < 15; i++) begin
          s = 12'($urandom_range(4095));
          if ($urandom_range(3) < busy) begin
            t = stim_time + 64'($urandom_range(3));
          end else begin
            case ($urandom_range(3))
              0: t = stim_time + 64'($urandom_range(70000));
              1: t = {$urandom, $urandom};
              2: begin
                t = stim_time + 64'($urandom_range(3));
                s = stim_sample;
              end
              default: t = stim_time + 64'($urandom_range(200));
            endcase
          end
          send_word(s, t);
        end
      end
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
  endtask

  // result checker with random back-pressure
  initial begin
    vol_result_t want;
    int          stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_stalls ? 0 : $urandom_range(11);
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (volume_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word volume %0d rate %0d count %0d", $time,
                 out_volume, out_change_rate, out_active_count);
      end else begin
        want = volume_due.pop_front();
        if (out_volume !== want.volume) begin
          fail_count++;
          $display("%0t: volume expected %0d got %0d", $time, want.volume, out_volume);
        end
        if (out_change_rate !== want.rate) begin
          fail_count++;
          $display("%0t: change_rate expected %0d got %0d", $time, want.rate,
                   out_change_rate);
        end
        if (out_active_count !== want.count) begin
          fail_count++;
          $display("%0t: active_count expected %0d got %0d", $time, want.count,
                   out_active_count);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_time_us = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    stim_sample = '0;
    stim_time = '0;
    gain_r = awv_pkg::GAIN_RST;
    thresh_r = awv_pkg::THRESHOLD_RST;
    low_r = awv_pkg::COUNT_LOW_RST;
    high_r = awv_pkg::COUNT_HIGH_RST;
    maxvol_r = awv_pkg::CLIP_VOLUME_RST;
    last_scaled = '0;
    last_time = '0;
    ring_ptr = 0;
    act_count = 0;
    for (int i = 0; i < awv_pkg::WINDOW_DEPTH_DEF; i++) flag_ring[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_time_edges();
    test_gain_edges();
    test_random_phases();

    @(negedge clk);
    in_valid = 1'b0;
    while (volume_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
